FILE: hdl/sbcr_pkg.sv
package sbcr_pkg;

   // fixed field widths
   localparam int POS_W    = 32;
   localparam int SIZE_W   = 21;
   localparam int DT_W     = 16;
   localparam int DT_BITS  = 16;
   // signed numerator width and its magnitude width
   localparam int NUM_W    = 35;
   localparam int NUM_ABS_W = 34;
   // velocity times frame time
   localparam int PROD_W   = POS_W + DT_W + 1;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_BOX_SIZE_X = 2'd0,
      CSR_BOX_SIZE_Y = 2'd1,
      CSR_BOX_SIZE_Z = 2'd2
   } csr_index_type;

   // axis codes
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // per-item control that rides alongside the dividers
   typedef struct packed {
      logic       valid;
      logic       any_vel;
      logic [2:0] zero;
      logic [2:0] in_slab;
      logic [2:0] near_neg;
      logic [2:0] far_neg;
   } ctl_type;

   // one result item
   typedef struct packed {
      logic signed [POS_W-1:0] push_x;
      logic signed [POS_W-1:0] push_y;
      logic signed [POS_W-1:0] push_z;
      logic                    hit;
   } res_type;

endpackage

FILE: hdl/sbcr_front.sv
module sbcr_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     enable,
   input  logic                                     in_valid,
   input  logic [2:0][sbcr_pkg::POS_W-1:0]          pos,
   input  logic [2:0][sbcr_pkg::POS_W-1:0]          vel,
   input  logic [2:0][sbcr_pkg::POS_W-1:0]          blk,
   input  logic [2:0][sbcr_pkg::SIZE_W-1:0]         size,
   input  logic [sbcr_pkg::DT_W-1:0]                dt,
   output sbcr_pkg::ctl_type                        ctl,
   output logic [2:0][sbcr_pkg::POS_W-1:0]          disp,
   output logic [2:0][sbcr_pkg::POS_W-1:0]          disp_abs,
   output logic [2:0][sbcr_pkg::NUM_ABS_W-1:0]      near_abs,
   output logic [2:0][sbcr_pkg::NUM_ABS_W-1:0]      far_abs
);

   localparam int NW = sbcr_pkg::NUM_W;
   localparam int PW = sbcr_pkg::PROD_W;
   localparam logic signed [NW-1:0] ONE_N = NW'(64'd1 << FRAC_BITS);

   // stage 1 registers
   logic                              v1_ff, v1_in;
   logic                              any1_ff, any1_in;
   logic [2:0][PW-1:0]                prod_ff, prod_in;
   logic [2:0][NW-1:0]                nnum_ff, nnum_in, fnum_ff, fnum_in;

   // stage 2 registers
   sbcr_pkg::ctl_type                 ctl_ff, ctl_in;
   logic [2:0][sbcr_pkg::POS_W-1:0]   d_ff, d_in, ad_ff, ad_in;
   logic [2:0][sbcr_pkg::NUM_ABS_W-1:0] an_ff, an_in, af_ff, af_in;

   // step displacement product and slab numerators
   always_comb begin
      v1_in   = in_valid;
      any1_in = |vel;
      for (int a = 0; a < 3; a++) begin
         prod_in[a] = PW'($signed(vel[a])) * PW'($signed({1'b0, dt}));
         nnum_in[a] = NW'($signed(blk[a])) - $signed(NW'(size[a])) - NW'($signed(pos[a]));
         fnum_in[a] = NW'($signed(blk[a])) + ONE_N - NW'($signed(pos[a]));
      end
   end

   // displacement, magnitudes and signs
   always_comb begin
      logic signed [sbcr_pkg::POS_W-1:0] d;
      logic signed [NW-1:0]              nn, fn, nabs, fabs;
      ctl_in         = '0;
      ctl_in.valid   = v1_ff;
      ctl_in.any_vel = any1_ff;
      for (int a = 0; a < 3; a++) begin
         d  = $signed(prod_ff[a][sbcr_pkg::DT_BITS +: sbcr_pkg::POS_W]);
         nn = $signed(nnum_ff[a]);
         fn = $signed(fnum_ff[a]);
         nabs = nn[NW-1] ? -nn : nn;
         fabs = fn[NW-1] ? -fn : fn;
         d_in[a]  = d;
         ad_in[a] = d[sbcr_pkg::POS_W-1] ? -d : d;
         an_in[a] = nabs[sbcr_pkg::NUM_ABS_W-1:0];
         af_in[a] = fabs[sbcr_pkg::NUM_ABS_W-1:0];
         ctl_in.zero[a]     = (d == '0);
         ctl_in.in_slab[a]  = nn[NW-1] && !fn[NW-1] && (fn != '0);
         ctl_in.near_neg[a] = nn[NW-1] ^ d[sbcr_pkg::POS_W-1];
         ctl_in.far_neg[a]  = fn[NW-1] ^ d[sbcr_pkg::POS_W-1];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         ctl_ff <= '0;
      end else if (enable) begin
         v1_ff  <= v1_in;
         ctl_ff <= ctl_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (enable) begin
         any1_ff <= any1_in;
         prod_ff <= prod_in;
         nnum_ff <= nnum_in;
         fnum_ff <= fnum_in;
         d_ff    <= d_in;
         ad_ff   <= ad_in;
         an_ff   <= an_in;
         af_ff   <= af_in;
      end
   end

   assign ctl      = ctl_ff;
   assign disp     = d_ff;
   assign disp_abs = ad_ff;
   assign near_abs = an_ff;
   assign far_abs  = af_ff;

endmodule

FILE: hdl/sbcr_div.sv
module sbcr_div #(
   parameter int NW = 50,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [DW-1:0] divisor,
   input  logic [NW-1:0] num_a,
   input  logic [NW-1:0] num_b,
   output logic [NW-1:0] quo_a,
   output logic [NW-1:0] quo_b
);

   // one quotient bit per stage, two dividends share the divisor line
   logic [DW-1:0] div_ff   [NW];
   logic [DW-1:0] rem_a_ff [NW];
   logic [DW-1:0] rem_b_ff [NW];
   logic [NW-1:0] wrk_a_ff [NW];
   logic [NW-1:0] wrk_b_ff [NW];

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic [DW-1:0] src_div, src_ra, src_rb, rem_a_in, rem_b_in;
      logic [NW-1:0] src_wa, src_wb;
      logic [DW:0]   trial_a, trial_b, diff_a, diff_b;
      logic          ge_a, ge_b;

      if (s == 0) begin : g_first
         assign src_div = divisor;
         assign src_ra  = '0;
         assign src_rb  = '0;
         assign src_wa  = num_a;
         assign src_wb  = num_b;
      end else begin : g_next
         assign src_div = div_ff[s-1];
         assign src_ra  = rem_a_ff[s-1];
         assign src_rb  = rem_b_ff[s-1];
         assign src_wa  = wrk_a_ff[s-1];
         assign src_wb  = wrk_b_ff[s-1];
      end

      // trial subtract of the shifted remainder
      always_comb begin
         trial_a  = {src_ra, src_wa[NW-1]};
         trial_b  = {src_rb, src_wb[NW-1]};
         diff_a   = trial_a - {1'b0, src_div};
         diff_b   = trial_b - {1'b0, src_div};
         ge_a     = (trial_a >= {1'b0, src_div});
         ge_b     = (trial_b >= {1'b0, src_div});
         rem_a_in = ge_a ? diff_a[DW-1:0] : trial_a[DW-1:0];
         rem_b_in = ge_b ? diff_b[DW-1:0] : trial_b[DW-1:0];
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            div_ff[s]   <= src_div;
            rem_a_ff[s] <= rem_a_in;
            rem_b_ff[s] <= rem_b_in;
            wrk_a_ff[s] <= {src_wa[NW-2:0], ge_a};
            wrk_b_ff[s] <= {src_wb[NW-2:0], ge_b};
         end
      end
   end

   assign quo_a = wrk_a_ff[NW-1];
   assign quo_b = wrk_b_ff[NW-1];

endmodule

FILE: hdl/sbcr_resolve.sv
module sbcr_resolve #(
   parameter int FRAC_BITS = 16,
   parameter int NW = 50
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             enable,
   input  sbcr_pkg::ctl_type                ctl,
   input  logic [2:0][sbcr_pkg::POS_W-1:0]  disp,
   input  logic [2:0][NW-1:0]               quo_near,
   input  logic [2:0][NW-1:0]               quo_far,
   output logic                             res_valid,
   output sbcr_pkg::res_type                res
);

   localparam int TW = NW + 2;
   localparam int OW = FRAC_BITS + 1;
   localparam int PW = sbcr_pkg::POS_W + FRAC_BITS + 2;
   localparam logic signed [TW-1:0] BIG   = TW'(1) << NW;
   localparam logic signed [TW-1:0] ONE_T = TW'(64'd1 << FRAC_BITS);
   localparam logic signed [PW-1:0] SMAX  = PW'(64'sh7FFFFFFF);
   localparam logic signed [PW-1:0] SMIN  = -PW'(64'sh80000000);

   // stage r1: signed ordered slab times
   logic                      v1_ff;
   logic                      any1_ff, miss1_ff, miss1_in;
   logic [2:0][TW-1:0]        nr_ff, nr_in, fr_ff, fr_in;
   logic [2:0][sbcr_pkg::POS_W-1:0] d1_ff;

   always_comb begin
      logic signed [TW-1:0] tn, tf;
      miss1_in = |(ctl.zero & ~ctl.in_slab);
      for (int a = 0; a < 3; a++) begin
         tn = $signed({2'b00, quo_near[a]});
         tf = $signed({2'b00, quo_far[a]});
         if (ctl.near_neg[a]) tn = -tn;
         if (ctl.far_neg[a])  tf = -tf;
         if (ctl.zero[a]) begin
            nr_in[a] = ctl.in_slab[a] ? -BIG : '0;
            fr_in[a] = ctl.in_slab[a] ? BIG : '0;
         end else if (tn > tf) begin
            nr_in[a] = tf;
            fr_in[a] = tn;
         end else begin
            nr_in[a] = tn;
            fr_in[a] = tf;
         end
      end
   end

   // stage r2: overlap test, axis choice, entry time range
   logic                      v2_ff, hit2_ff, hit2_in;
   logic [1:0]                k2_ff, k2_in;
   logic [OW-1:0]             om2_ff, om2_in;
   logic [sbcr_pkg::POS_W-1:0] dk2_ff;

   always_comb begin
      logic                 fail;
      logic signed [TW-1:0] t, rest;
      fail = 1'b0;
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            if (a != b && $signed(nr_ff[a]) > $signed(fr_ff[b])) fail = 1'b1;
         end
      end
      if ($signed(nr_ff[0]) > $signed(nr_ff[1])) begin
         k2_in = ($signed(nr_ff[0]) > $signed(nr_ff[2])) ? sbcr_pkg::AXIS_X : sbcr_pkg::AXIS_Z;
      end else begin
         k2_in = ($signed(nr_ff[1]) > $signed(nr_ff[2])) ? sbcr_pkg::AXIS_Y : sbcr_pkg::AXIS_Z;
      end
      t       = $signed(nr_ff[k2_in]);
      rest    = ONE_T - t;
      om2_in  = rest[OW-1:0];
      hit2_in = any1_ff && !miss1_ff && !fail && !t[TW-1] && (t <= ONE_T);
   end

   // stage r3: displacement times remaining time
   logic                      v3_ff, hit3_ff;
   logic [1:0]                k3_ff;
   logic [PW-1:0]             prod3_ff, prod3_in;

   assign prod3_in = PW'($signed(dk2_ff)) * PW'($signed({1'b0, om2_ff}));

   // stage r4: negate, floor, saturate, place on the chosen axis
   logic                      v4_ff;
   sbcr_pkg::res_type         res4_ff, res4_in;

   always_comb begin
      logic signed [PW-1:0]             np, sh;
      logic signed [sbcr_pkg::POS_W-1:0] sat;
      np = -$signed(prod3_ff);
      sh = np >>> FRAC_BITS;
      if (sh > SMAX)      sat = sbcr_pkg::POS_W'(SMAX);
      else if (sh < SMIN) sat = sbcr_pkg::POS_W'(SMIN);
      else                sat = sh[sbcr_pkg::POS_W-1:0];
      res4_in        = '0;
      res4_in.hit    = hit3_ff;
      res4_in.push_x = (hit3_ff && k3_ff == sbcr_pkg::AXIS_X) ? sat : '0;
      res4_in.push_y = (hit3_ff && k3_ff == sbcr_pkg::AXIS_Y) ? sat : '0;
      res4_in.push_z = (hit3_ff && k3_ff == sbcr_pkg::AXIS_Z) ? sat : '0;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= ctl.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (enable) begin
         any1_ff  <= ctl.any_vel;
         miss1_ff <= miss1_in;
         nr_ff    <= nr_in;
         fr_ff    <= fr_in;
         d1_ff    <= disp;
         hit2_ff  <= hit2_in;
         k2_ff    <= k2_in;
         om2_ff   <= om2_in;
         dk2_ff   <= d1_ff[k2_in];
         hit3_ff  <= hit2_ff;
         k3_ff    <= k2_ff;
         prod3_ff <= prod3_in;
         res4_ff  <= res4_in;
      end
   end

   assign res_valid = v4_ff;
   assign res       = res4_ff;

endmodule

FILE: hdl/swept_box_collision_response_unit.sv
// Swept box-versus-block collision test. Each transfer carries a moving box corner and
// velocity, a unit block corner and a frame time; the box extent comes from three size
// registers written on the csr port (index 0..2 = x, y, z; other indexes are ignored); the
// user must write them only while the unit is idle, which the unit does not enforce. Every
// request gives exactly one response with the push-back vector on the latest-entry axis and
// a hit flag. The unit takes one request per clock while req_stall is low; its restoring
// divider pipeline resolves one quotient bit per stage over 34 + FRAC_BITS stages. A
// two-entry output buffer keeps the request side moving after a response stall until full.
module swept_box_collision_response_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [sbcr_pkg::POS_W-1:0]      req_box_pos_x,
   input  logic signed [sbcr_pkg::POS_W-1:0]      req_box_pos_y,
   input  logic signed [sbcr_pkg::POS_W-1:0]      req_box_pos_z,
   input  logic signed [sbcr_pkg::POS_W-1:0]      req_vel_x,
   input  logic signed [sbcr_pkg::POS_W-1:0]      req_vel_y,
   input  logic signed [sbcr_pkg::POS_W-1:0]      req_vel_z,
   input  logic signed [sbcr_pkg::POS_W-1:0]      req_block_x,
   input  logic signed [sbcr_pkg::POS_W-1:0]      req_block_y,
   input  logic signed [sbcr_pkg::POS_W-1:0]      req_block_z,
   input  logic [sbcr_pkg::DT_W-1:0]              req_frame_time,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [sbcr_pkg::POS_W-1:0]      rsp_push_x,
   output logic signed [sbcr_pkg::POS_W-1:0]      rsp_push_y,
   output logic signed [sbcr_pkg::POS_W-1:0]      rsp_push_z,
   output logic                                   rsp_hit,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [1:0]                             csr_index,
   input  logic [sbcr_pkg::SIZE_W-1:0]            csr_data
);

   localparam int NW = sbcr_pkg::NUM_ABS_W + FRAC_BITS;
   localparam int DW = sbcr_pkg::POS_W;

   // size registers
   logic [2:0][sbcr_pkg::SIZE_W-1:0] size_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sbcr_pkg::CSR_BOX_SIZE_X: size_ff[0] <= csr_data;
            sbcr_pkg::CSR_BOX_SIZE_Y: size_ff[1] <= csr_data;
            sbcr_pkg::CSR_BOX_SIZE_Z: size_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline advances while the output buffer has room
   logic skid_full_ff, skid_full_in;
   logic advance;

   assign advance   = !skid_full_ff;
   assign req_stall = skid_full_ff;

   // front end
   sbcr_pkg::ctl_type                   ctl_f;
   logic [2:0][DW-1:0]                  d_f, ad_f;
   logic [2:0][sbcr_pkg::NUM_ABS_W-1:0] an_f, af_f;

   sbcr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .in_valid (req_valid),
      .pos      ({req_box_pos_z, req_box_pos_y, req_box_pos_x}),
      .vel      ({req_vel_z, req_vel_y, req_vel_x}),
      .blk      ({req_block_z, req_block_y, req_block_x}),
      .size     (size_ff),
      .dt       (req_frame_time),
      .ctl      (ctl_f),
      .disp     (d_f),
      .disp_abs (ad_f),
      .near_abs (an_f),
      .far_abs  (af_f)
   );

   // one divider per axis, near and far numerators share the divisor
   logic [2:0][NW-1:0] qn, qf;

   for (genvar a = 0; a < 3; a++) begin : g_axis
      sbcr_div #(.NW(NW), .DW(DW)) u_div (
         .clock   (clock),
         .enable  (advance),
         .divisor (ad_f[a]),
         .num_a   ({an_f[a], FRAC_BITS'(0)}),
         .num_b   ({af_f[a], FRAC_BITS'(0)}),
         .quo_a   (qn[a]),
         .quo_b   (qf[a])
      );
   end

   // control and displacement delay matched to the dividers
   sbcr_pkg::ctl_type  dly_ctl_ff [NW];
   logic [2:0][DW-1:0] dly_d_ff   [NW];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NW; i++) dly_ctl_ff[i] <= '0;
      end else if (advance) begin
         dly_ctl_ff[0] <= ctl_f;
         for (int i = 1; i < NW; i++) dly_ctl_ff[i] <= dly_ctl_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dly_d_ff[0] <= d_f;
         for (int i = 1; i < NW; i++) dly_d_ff[i] <= dly_d_ff[i-1];
      end
   end

   // slab resolution and push computation
   logic              res_valid;
   sbcr_pkg::res_type res;

   sbcr_resolve #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_resolve (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .ctl       (dly_ctl_ff[NW-1]),
      .disp      (dly_d_ff[NW-1]),
      .quo_near  (qn),
      .quo_far   (qf),
      .res_valid (res_valid),
      .res       (res)
   );

   // output register and skid entry
   logic              out_valid_ff, out_valid_in;
   sbcr_pkg::res_type out_ff, out_in, skid_ff, skid_in;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      skid_full_in = skid_full_ff;
      skid_in      = skid_ff;
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_full_ff) begin
            out_in       = skid_ff;
            out_valid_in = 1'b1;
            skid_full_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = res_valid;
         end
      end else if (res_valid && !skid_full_ff) begin
         skid_in      = res;
         skid_full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_push_x = out_ff.push_x;
   assign rsp_push_y = out_ff.push_y;
   assign rsp_push_z = out_ff.push_z;
   assign rsp_hit    = out_ff.hit;

endmodule
